// ===== src/bmp_pu_pkg.sv =====
package bmp_pu_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned PalDepth = 256;
  localparam int unsigned PalIdxW  = 8;
  localparam int unsigned MaxWidth = 2048;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic {
    REQ_PALETTE = 1'b0,
    REQ_PIXEL   = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH    = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_ORIGIN_X = 3'd3,
    CFG_ORIGIN_Y = 3'd4
  } cfg_reg_e;

  // side information of one pixel while its palette read is in flight
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last_in;
    logic              last_img;
  } pix_info_t;

  function automatic logic [ColorW-1:0] rgb565(input logic [7:0] r,
                                               input logic [7:0] g,
                                               input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== src/bmp_palette_pixel_unpacker.sv =====
// Indexed-color BMP pixel unpacker. A beat with tuser low writes one palette
// entry (RGB888 folded to RGB565). A beat with tuser high carries the next
// byte of the BMP pixel array in file order; the byte is loaded into a shift
// register and one palette index is shifted out per cycle, MSB first, while
// the output is not stalled, for each pixel that falls inside the image
// width; a row padding byte yields no pixels. No new beat is accepted until
// the shifter has finished the current byte. Each pixel reads the single
// palette port into the palette read register and then moves to the output
// register, with tlast on the last pixel of its byte and tuser on the last
// pixel of the image. Write width, height, depth and origin only while the
// block is idle.
module bmp_palette_pixel_unpacker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // palette_index, red, green, blue, data_byte
  input  logic [bmp_pu_pkg::InDataW-1:0]     s_axis_tdata_i,
  // req_type
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color
  output logic [bmp_pu_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // last_of_image
  output logic                               m_axis_tuser_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmp_pu_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bmp_pu_pkg::CfgDataW-1:0]    cfg_data_i
);
  import bmp_pu_pkg::*;

  // configuration
  logic [1:0]        depth_q;
  logic [11:0]       width_q;
  logic [11:0]       height_q;
  logic [10:0]       origin_x_q;
  logic [10:0]       origin_y_q;

  // control
  state_e            state_q, state_d;
  logic [11:0]       col_q, col_d;
  logic [11:0]       row_q, row_d;
  logic [11:0]       rb_q, rb_d;
  logic [3:0]        k_q, k_d;
  logic [7:0]        sh_q, sh_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;

  // payload
  pix_info_t         pend_q;
  pix_info_t         out_info_q;
  logic [ColorW-1:0] out_color_q;
  logic [ColorW-1:0] pal_rd_q;
  logic [ColorW-1:0] pal_mem [PalDepth];

  // combinational
  logic [11:0]       eff_w, eff_h;
  logic [14:0]       row_bits;
  logic [15:0]       row_bits_rnd;
  logic [12:0]       pitch;
  logic [12:0]       rb_inc, row_inc, col_inc;
  logic [PalIdxW-1:0] pix_idx;
  logic [7:0]        sh_next;
  logic [3:0]        per_byte;
  logic              accept, pal_we, out_take, pend_free, issue, last_in, finish;
  pix_info_t         pix_info;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= 2'd3;
      width_q    <= 12'd1;
      height_q   <= 12'd1;
      origin_x_q <= 11'd0;
      origin_y_q <= 11'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEPTH:    depth_q    <= cfg_data_i[1:0];
        CFG_WIDTH:    width_q    <= cfg_data_i;
        CFG_HEIGHT:   height_q   <= cfg_data_i;
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i[10:0];
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == 12'd0) begin
      eff_w = 12'd1;
    end else if ({1'b0, width_q} > 13'(MaxWidth)) begin
      eff_w = 12'(MaxWidth);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q == 12'd0) ? 12'd1 : height_q;
  end

  // row pitch in bytes: bits per row rounded up to whole 32-bit words
  assign row_bits     = {3'd0, eff_w} << depth_q;
  assign row_bits_rnd = {1'b0, row_bits} + 16'd31;
  assign pitch        = {row_bits_rnd[15:5], 2'b00};

  assign rb_inc  = {1'b0, rb_q} + 13'd1;
  assign row_inc = {1'b0, row_q} + 13'd1;
  assign col_inc = {1'b0, col_q} + 13'd1;

  assign per_byte = 4'd8 >> depth_q;

  always_comb begin
    case (depth_q)
      2'd0: begin
        pix_idx = {7'd0, sh_q[7]};
        sh_next = {sh_q[6:0], 1'b0};
      end
      2'd1: begin
        pix_idx = {6'd0, sh_q[7:6]};
        sh_next = {sh_q[5:0], 2'b00};
      end
      2'd2: begin
        pix_idx = {4'd0, sh_q[7:4]};
        sh_next = {sh_q[3:0], 4'b0000};
      end
      default: begin
        pix_idx = sh_q;
        sh_next = 8'd0;
      end
    endcase
  end

  assign out_take  = !out_valid_q || m_axis_tready_i;
  assign pend_free = !pend_valid_q || out_take;
  assign issue     = (state_q == ST_RUN) && pend_free;
  assign last_in   = (k_q == 4'd1) || (col_inc >= {1'b0, eff_w});

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pal_we          = accept && (s_axis_tuser_i == REQ_PALETTE);

  assign pix_info.x        = CoordW'({1'b0, origin_x_q} + col_q);
  assign pix_info.y        = CoordW'({1'b0, origin_y_q} + eff_h - 12'd1 - row_q);
  assign pix_info.last_in  = last_in;
  assign pix_info.last_img = (col_q == eff_w - 12'd1) && (row_q == eff_h - 12'd1);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    rb_d         = rb_q;
    k_d          = k_q;
    sh_d         = sh_q;
    finish       = 1'b0;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;

    if (out_take) begin
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser_i == REQ_PIXEL)) begin
          if (col_q >= eff_w) begin
            // padding byte or unused tail of the row
            finish = 1'b1;
          end else begin
            sh_d    = s_axis_tdata_i[39:32];
            k_d     = per_byte;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          pend_valid_d = 1'b1;
          sh_d         = sh_next;
          k_d          = k_q - 4'd1;
          col_d        = col_inc[11:0];
          if (last_in) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // byte done: advance row position, wrap at end of row and image
    if (finish) begin
      rb_d = rb_inc[11:0];
      if (rb_inc >= pitch) begin
        rb_d  = 12'd0;
        col_d = 12'd0;
        row_d = (row_inc >= {1'b0, eff_h}) ? 12'd0 : row_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      col_q        <= 12'd0;
      row_q        <= 12'd0;
      rb_q         <= 12'd0;
      k_q          <= 4'd0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      rb_q         <= rb_d;
      k_q          <= k_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (issue) begin
      pend_q <= pix_info;
    end
    if (out_take && pend_valid_q) begin
      out_info_q  <= pend_q;
      out_color_q <= pal_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[s_axis_tdata_i[7:0]] <= rgb565(s_axis_tdata_i[15:8],
                                             s_axis_tdata_i[23:16],
                                             s_axis_tdata_i[31:24]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pal_rd_q <= pal_mem[pix_idx];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_color_q, out_info_q.y, out_info_q.x};
  assign m_axis_tlast_o  = out_info_q.last_in;
  assign m_axis_tuser_o  = out_info_q.last_img;

  a_run_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q != 4'd0))
    else $error("shifter running with no pixels left in the byte");

  a_image_end_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("last pixel of image not flagged as last of its byte");

  a_no_accept_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_in) |=> (state_q == ST_IDLE) && pend_valid_q)
    else $error("last pixel of byte lost between shifter and lookup stage");

endmodule

// ===== dv/bmp_pu_checker.sv =====
`timescale 1ns / 100ps

module bmp_pu_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // palette_index, red, green, blue, data_byte
  input  logic [bmp_pu_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                            s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color
  input  logic [bmp_pu_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                            m_axis_tlast_i,
  // last_of_image
  input  logic                            m_axis_tuser_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [bmp_pu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmp_pu_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import bmp_pu_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              last_in;
    logic              last_img;
  } pixel_t;

  logic [ColorW-1:0] palette_mem [PalDepth];
  logic [1:0]        depth_sel;
  logic [11:0]       img_w;
  logic [11:0]       img_h;
  logic [10:0]       org_x;
  logic [10:0]       org_y;
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  int unsigned       row_bytes;
  pixel_t            pending_pixels [$];
  int unsigned       fails;

  task automatic unpack_byte(input logic [7:0] data);
    int unsigned bpp;
    int unsigned per_byte;
    int unsigned w;
    int unsigned h;
    int unsigned pitch;
    int unsigned idx;
    int unsigned k;
    pixel_t      px;
    bpp      = 1 << depth_sel;
    per_byte = 8 >> depth_sel;
    w        = (img_w == 0) ? 1 : ((img_w > MaxWidth) ? MaxWidth : img_w);
    h        = (img_h == 0) ? 1 : img_h;
    pitch    = ((w * bpp + 31) / 32) * 4;
    for (k = 0; k < per_byte; k++) begin
      // columns past the image width are unused bits
      if (col_cnt < w) begin
        idx          = (data >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
        px.color     = (idx < PalDepth) ? palette_mem[idx] : '0;
        px.x         = CoordW'(org_x + col_cnt);
        px.y         = CoordW'(org_y + h - 1 - row_cnt);
        px.last_in   = (k == per_byte - 1) || (col_cnt + 1 >= w);
        px.last_img  = (col_cnt == w - 1) && (row_cnt == h - 1);
        pending_pixels.push_back(px);
        col_cnt++;
      end
    end
    row_bytes++;
    if (row_bytes >= pitch) begin
      row_bytes = 0;
      col_cnt   = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      depth_sel = 2'd3;
      img_w     = 12'd1;
      img_h     = 12'd1;
      org_x     = '0;
      org_y     = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      row_bytes = 0;
      fails     = 0;
      pending_pixels.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // check the output side first so a result never matches its own byte
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.x        = m_axis_tdata_i[11:0];
        got.y        = m_axis_tdata_i[23:12];
        got.color    = m_axis_tdata_i[39:24];
        got.last_in  = m_axis_tlast_i;
        got.last_img = m_axis_tuser_i;
        if (pending_pixels.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b img_last=%b",
                     $time, got.x, got.y, got.color, got.last_in, got.last_img);
          fails++;
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            if (fails < 10) begin
              $display("%0t: pixel mismatch", $time);
              $display("  expected x=%0d y=%0d color=%h last=%b img_last=%b",
                       want.x, want.y, want.color, want.last_in, want.last_img);
              $display("  actual   x=%0d y=%0d color=%h last=%b img_last=%b",
                       got.x, got.y, got.color, got.last_in, got.last_img);
            end
            fails++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (req_e'(s_axis_tuser_i) == REQ_PALETTE)
          palette_mem[s_axis_tdata_i[7:0]] = {s_axis_tdata_i[15:11],
                                              s_axis_tdata_i[23:18],
                                              s_axis_tdata_i[31:27]};
        else
          unpack_byte(s_axis_tdata_i[39:32]);
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_DEPTH:    depth_sel = cfg_data_i[1:0];
          CFG_WIDTH:    img_w     = cfg_data_i;
          CFG_HEIGHT:   img_h     = cfg_data_i;
          CFG_ORIGIN_X: org_x     = cfg_data_i[10:0];
          CFG_ORIGIN_Y: org_y     = cfg_data_i[10:0];
          default: ;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= pending_pixels.size();
    end
  end

endmodule

// ===== dv/tb_bmp_palette_pixel_unpacker.sv =====
`timescale 1ns / 100ps

module tb_bmp_palette_pixel_unpacker;
  import bmp_pu_pkg::*;

  localparam int unsigned SettleCycles = 30;
  localparam int unsigned RandomItems  = 140;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  int unsigned         fails;
  int unsigned         pending;
  bit                  idle_en   = 1'b1;

  bmp_palette_pixel_unpacker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  bmp_pu_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fails),
    .pending_o       (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("bmp_palette_pixel_unpacker test failed");
    $finish;
  end

  // pixel sink: stall in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send_beat(input req_e kind, input logic [InDataW-1:0] data);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
    send_beat(REQ_PALETTE, {8'($urandom()), b, g, r, idx});
  endtask

  task automatic send_pixels(input logic [7:0] data);
    send_beat(REQ_PIXEL, {data, 32'($urandom())});
  endtask

  // hold until every pixel is out and the pipeline has drained
  task automatic wait_idle();
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic configure(input logic [1:0] depth, input logic [11:0] w,
                           input logic [11:0] h, input logic [10:0] ox,
                           input logic [10:0] oy);
    wait_idle();
    write_reg(CFG_DEPTH, 12'(depth));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_ORIGIN_X, 12'(ox));
    write_reg(CFG_ORIGIN_Y, 12'(oy));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_image(input int unsigned n_items, input int unsigned pal_pct);
    int unsigned i;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < pal_pct)
        send_palette(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
      else
        send_pixels(8'($urandom()));
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    int unsigned i;
    int unsigned sent;
    int unsigned depth;
    int unsigned w;
    int unsigned h;
    int unsigned ox;
    int unsigned oy;
    int unsigned pitch;
    int unsigned n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    configure(2'd3, 12'd1, 12'd1, 11'd0, 11'd0);
    // fill the whole palette so no lookup hits an unwritten entry
    for (i = 0; i < PalDepth; i++)
      send_palette(8'(i), 8'($urandom()), 8'($urandom()), 8'($urandom()));

    // 8 bpp, 1x1: one pixel then three padding bytes per row
    send_palette(8'h00, 8'h00, 8'h00, 8'h00);
    send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixels(8'hFF);
    send_pixels(8'h00);
    send_pixels(8'hAA);
    send_pixels(8'h55);
    send_pixels(8'h00);
    send_pixels(8'hFF);
    send_pixels(8'h0F);
    send_pixels(8'hF0);
    s_tvalid <= 1'b0;

    // 1 bpp, 13 wide at the far corner: a partial byte and two padding bytes
    configure(2'd0, 12'd13, 12'd2, 11'd2047, 11'd2047);
    send_pixels(8'hAA);
    send_pixels(8'h55);
    send_palette(8'h01, 8'h07, 8'hFB, 8'h04);
    send_pixels(8'hFF);
    send_pixels(8'h00);
    // drain everything before the next row
    s_tvalid <= 1'b0;
    wait_idle();
    send_pixels(8'h00);
    send_pixels(8'hFF);
    send_pixels(8'h12);
    send_pixels(8'h34);
    s_tvalid <= 1'b0;

    configure(2'd1, 12'd4, 12'd1, 11'd5, 11'd9);
    send_pixels(8'hE4);
    send_pixels(8'h1B);
    s_tvalid <= 1'b0;

    configure(2'd2, 12'd3, 12'd2, 11'd0, 11'd0);
    send_pixels(8'h0F);
    send_pixels(8'hF0);
    send_pixels(8'hC3);
    send_pixels(8'h3C);
    s_tvalid <= 1'b0;

    // zero width and height act as one
    configure(2'd0, 12'd0, 12'd0, 11'd0, 11'd0);
    run_image(8, 0);

    // width above the limit clamps to the widest row
    configure(2'd0, 12'hFFF, 12'd2, 11'd0, 11'd0);
    run_image(20, 0);

    sent = 0;
    while (sent < RandomItems) begin
      depth = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0:       w = MaxWidth;
        1:       w = 1;
        default: w = $urandom_range(1, 40);
      endcase
      h  = ($urandom_range(0, 9) == 0) ? MaxWidth : $urandom_range(1, 6);
      ox = ($urandom_range(0, 4) == 0) ? 2047 * $urandom_range(0, 1) : $urandom_range(0, 2047);
      oy = ($urandom_range(0, 4) == 0) ? 2047 * $urandom_range(0, 1) : $urandom_range(0, 2047);
      pitch = (((w << depth) + 31) / 32) * 4;
      n = pitch * h * $urandom_range(1, 2) + $urandom_range(0, 5);
      if (n > 80) n = $urandom_range(20, 80);
      if (n > RandomItems - sent) n = RandomItems - sent;
      configure(2'(depth), 12'(w), 12'(h), 11'(ox), 11'(oy));
      idle_en = (sent + n > RandomItems - 70) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_image(n, 12);
      sent += n;
    end

    wait_idle();
    if (fails == 0 && pending == 0) begin
      $display("bmp_palette_pixel_unpacker test passed");
    end else begin
      $display("bmp_palette_pixel_unpacker test failed");
    end
    $finish;
  end

endmodule
